@@ rtl/ttip_pkg.sv @@
// Package: constants, types and character helpers of the text-to-integer parser.
`timescale 1ns / 1ps

package ttip_pkg;

  localparam int unsigned OFFSET_W = 16;
  localparam int unsigned BASE_W   = 6;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned VALUE_W  = 64;
  localparam int unsigned DIGIT_W  = 6;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 6;

  localparam logic [OFFSET_W-1:0] MAX_OFFSET = 16'hFFFF;

  localparam logic [BASE_W-1:0] BASE_AUTO     = 6'd0;
  localparam logic [BASE_W-1:0] BASE_INVALID  = 6'd1;
  localparam logic [BASE_W-1:0] BASE_MIN      = 6'd2;
  localparam logic [BASE_W-1:0] BASE_OCT      = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC      = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX      = 6'd16;
  localparam logic [BASE_W-1:0] BASE_MAX      = 6'd36;
  localparam logic [BASE_W-1:0] BASE_RESET    = 6'd10;

  localparam logic [KIND_W-1:0] KIND_RESET    = 2'd1;
  localparam int unsigned KIND_SIGNED_BIT = 0;
  localparam int unsigned KIND_WIDE_BIT   = 1;

  localparam logic [VALUE_W-1:0] MASK_32 = 64'h0000_0000_FFFF_FFFF;
  localparam logic [VALUE_W-1:0] MASK_64 = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [VALUE_W-1:0] LIM_U32 = 64'h0000_0000_FFFF_FFFF;
  localparam logic [VALUE_W-1:0] LIM_S32 = 64'h0000_0000_8000_0000;
  localparam logic [VALUE_W-1:0] LIM_U64 = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [VALUE_W-1:0] LIM_S64 = 64'h8000_0000_0000_0000;

  localparam logic [DIGIT_W-1:0] DIGIT_NONE = 6'd36;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
  localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

  localparam logic [CFG_IDX_W-1:0] REG_NUMBER_BASE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESULT_KIND = 1'd1;

  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_LEAD   = 6'b000010,
    PH_START  = 6'b000100,
    PH_ZERO   = 6'b001000,
    PH_XSEEN  = 6'b010000,
    PH_DIGITS = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_byte;
    logic              string_start;
  } item_t;

  typedef struct packed {
    logic                bad_base;
    logic                dseen;
    logic                neg;
    logic                ovf;
    logic [KIND_W-1:0]   kind;
    logic [VALUE_W-1:0]  mag;
    logic [OFFSET_W-1:0] end_offset;
  } emit_t;

  function automatic logic [DIGIT_W-1:0] char_digit(input logic [CHAR_W-1:0] c);
    logic [DIGIT_W-1:0] d;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = DIGIT_W'(c - CH_ZERO);
    end else if (c >= CH_LA && c <= CH_LZ) begin
      d = DIGIT_W'(c - CH_LA) + BASE_DEC;
    end else if (c >= CH_UA && c <= CH_UZ) begin
      d = DIGIT_W'(c - CH_UA) + BASE_DEC;
    end else begin
      d = DIGIT_NONE;
    end
    return d;
  endfunction

  function automatic logic is_blank(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic [VALUE_W-1:0] kind_limit(input logic [KIND_W-1:0] k);
    logic [VALUE_W-1:0] lim;
    case (k)
      2'd0:    lim = LIM_U32;
      2'd1:    lim = LIM_S32;
      2'd2:    lim = LIM_U64;
      default: lim = LIM_S64;
    endcase
    return lim;
  endfunction

endpackage

@@ rtl/ttip_if.sv @@
// Interfaces: character input channel and result output channel.
`timescale 1ns / 1ps

interface ttip_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       string_start;

  modport source (output valid, output char_byte, output string_start, input ready);
  modport sink   (input valid, input char_byte, input string_start, output ready);
endinterface

interface ttip_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] parsed_value;
  logic        range_error;
  logic        bad_base;
  logic [15:0] end_offset;

  modport source (output valid, output parsed_value, output range_error, output bad_base,
                  output end_offset, input ready);
  modport sink   (input valid, input parsed_value, input range_error, input bad_base,
                  input end_offset, output ready);
endinterface

@@ rtl/text_to_integer_parser.sv @@
// Top level of the streaming text-to-integer parser.
// Usage:
//   in  channel: one character per transaction (char_byte), string_start set on the
//       first byte of each string; a new start abandons any unfinished parse.
//   out channel: at most one transaction per string with parsed_value, range_error,
//       bad_base and end_offset, given on the byte that ends the number (or on the
//       start byte when the latched base is invalid).
//   cfg port: cfg_write_en/cfg_index/cfg_data write number_base (index 0) and
//       result_kind (index 1); both are latched when a string starts.
// Path: the result for a string's ending byte passes the input register, then the
//   result register.
// Throughput: one character per cycle unless stalled, set by the accumulate step
//   (64 by 6 bit multiply, digit add and limit compare) between input and result registers.
// Reset: rst is synchronous; it empties both registers, returns the parser to idle
//   and sets number_base to 10 and result_kind to signed 32 bit.
// Stall: while a result waits, one more character is taken into the input register;
//   further input is held off until the result transaction completes.
`timescale 1ns / 1ps

module text_to_integer_parser (
  input  logic                              clk,
  input  logic                              rst,
  ttip_in_if.sink                           in,
  ttip_out_if.source                        out,
  input  logic                              cfg_write_en,
  input  logic [ttip_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ttip_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [ttip_pkg::BASE_W-1:0] number_base;
  logic [ttip_pkg::KIND_W-1:0] result_kind;
  logic                        item_vld;
  ttip_pkg::item_t             item;
  logic                        open_slot;
  logic                        step;
  logic                        emit_valid;
  ttip_pkg::emit_t             emit_rec;

  always_ff @(posedge clk) begin
    if (rst) begin
      number_base <= ttip_pkg::BASE_RESET;
      result_kind <= ttip_pkg::KIND_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        ttip_pkg::REG_NUMBER_BASE: number_base <= cfg_data[ttip_pkg::BASE_W-1:0];
        ttip_pkg::REG_RESULT_KIND: result_kind <= cfg_data[ttip_pkg::KIND_W-1:0];
        default: ;
      endcase
    end
  end

  assign step = item_vld && open_slot;

  ttip_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .in       (in),
    .take     (step),
    .item_vld (item_vld),
    .item     (item)
  );

  ttip_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .item        (item),
    .number_base (number_base),
    .result_kind (result_kind),
    .emit_valid  (emit_valid),
    .emit_rec    (emit_rec)
  );

  ttip_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .load      (step && emit_valid),
    .rec       (emit_rec),
    .open_slot (open_slot),
    .out       (out)
  );

`ifndef SYNTHESIS
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out.valid |-> in.ready)
    else $error("input held off with an empty result register");

  a_bad_base_clean: assert property (@(posedge clk) disable iff (rst)
    out.valid && out.bad_base |->
      out.parsed_value == 64'd0 && !out.range_error && out.end_offset == 16'd0)
    else $error("invalid-base result carries data");

  a_range_has_digits: assert property (@(posedge clk) disable iff (rst)
    out.valid && out.range_error |-> out.end_offset != 16'd0 && !out.bad_base)
    else $error("range error without digits");

  a_start_bad_base_emits: assert property (@(posedge clk) disable iff (rst)
    step && item.string_start && number_base == ttip_pkg::BASE_INVALID |=>
      out.valid && out.bad_base)
    else $error("invalid base did not produce a result");
`endif

endmodule

@@ rtl/ttip_in_stage.sv @@
// Input register: holds one accepted character transaction for the parse step.
`timescale 1ns / 1ps

module ttip_in_stage (
  input  logic            clk,
  input  logic            rst,
  ttip_in_if.sink         in,
  input  logic            take,
  output logic            item_vld,
  output ttip_pkg::item_t item
);

  assign in.ready = !item_vld || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_vld <= 1'b0;
    end else if (in.ready) begin
      item_vld <= in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in.valid && in.ready) begin
      item.char_byte    <= in.char_byte;
      item.string_start <= in.string_start;
    end
  end

endmodule

@@ rtl/ttip_mac.sv @@
// Accumulate unit: value*base+digit with saturation at the type limit.
`timescale 1ns / 1ps

module ttip_mac (
  input  logic [ttip_pkg::VALUE_W-1:0] acc,
  input  logic [ttip_pkg::BASE_W-1:0]  base,
  input  logic [ttip_pkg::DIGIT_W-1:0] digit,
  input  logic [ttip_pkg::VALUE_W-1:0] limit,
  input  logic                         ovf_in,
  output logic [ttip_pkg::VALUE_W-1:0] acc_out,
  output logic                         ovf_out
);

  localparam int unsigned PROD_W = ttip_pkg::VALUE_W + ttip_pkg::BASE_W;

  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] sum;
  logic              over;

  always_comb begin
    prod = PROD_W'(acc) * PROD_W'(base);
    sum  = prod + PROD_W'(digit);
    over = sum > PROD_W'(limit);
    ovf_out = ovf_in || over;
    if (over) begin
      acc_out = limit;
    end else if (ovf_in) begin
      acc_out = acc;
    end else begin
      acc_out = sum[ttip_pkg::VALUE_W-1:0];
    end
  end

endmodule

@@ rtl/ttip_core.sv @@
// Parse sequencer: prefix, sign and digit phases with the running accumulator.
`timescale 1ns / 1ps

module ttip_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  ttip_pkg::item_t               item,
  input  logic [ttip_pkg::BASE_W-1:0]   number_base,
  input  logic [ttip_pkg::KIND_W-1:0]   result_kind,
  output logic                          emit_valid,
  output ttip_pkg::emit_t               emit_rec
);

  ttip_pkg::phase_t                   phase, phase_next, phase_e;
  logic                               sign_neg, sign_neg_next, sign_e;
  logic                               ovf, ovf_next, ovf_e;
  logic                               dseen, dseen_next, dseen_e;
  logic [ttip_pkg::BASE_W-1:0]        active_base, active_base_next, active_e;
  logic [ttip_pkg::BASE_W-1:0]        base_l, base_l_next, base_e;
  logic [ttip_pkg::KIND_W-1:0]        kind_l, kind_l_next, kind_e;
  logic [ttip_pkg::VALUE_W-1:0]       acc, acc_next, acc_e;
  logic [ttip_pkg::OFFSET_W-1:0]      char_index, char_index_next, idx;
  logic [ttip_pkg::OFFSET_W-1:0]      dstart, dstart_next, dstart_e;

  logic [ttip_pkg::CHAR_W-1:0]        c;
  logic [ttip_pkg::DIGIT_W-1:0]       d;
  logic                               base_bad;
  logic [ttip_pkg::BASE_W-1:0]        mac_base;
  logic [ttip_pkg::VALUE_W-1:0]       mac_acc;
  logic [ttip_pkg::VALUE_W-1:0]       mac_acc_out;
  logic                               mac_ovf_out;
  logic [ttip_pkg::VALUE_W-1:0]       limit;
  logic                               digit_go;
  logic                               digit_dseen;
  logic                               digit_ends;
  logic [ttip_pkg::OFFSET_W-1:0]      xpos;

  assign c        = item.char_byte;
  assign d        = ttip_pkg::char_digit(item.char_byte);
  assign base_bad = (number_base == ttip_pkg::BASE_INVALID) ||
                    (number_base > ttip_pkg::BASE_MAX);

  always_comb begin
    if (item.string_start) begin
      phase_e  = base_bad ? ttip_pkg::PH_IDLE : ttip_pkg::PH_LEAD;
      base_e   = number_base;
      kind_e   = result_kind;
      sign_e   = 1'b0;
      ovf_e    = 1'b0;
      dseen_e  = 1'b0;
      acc_e    = '0;
      active_e = '0;
      dstart_e = '0;
      idx      = '0;
    end else begin
      phase_e  = phase;
      base_e   = base_l;
      kind_e   = kind_l;
      sign_e   = sign_neg;
      ovf_e    = ovf;
      dseen_e  = dseen;
      acc_e    = acc;
      active_e = active_base;
      dstart_e = dstart;
      if (phase != ttip_pkg::PH_IDLE && char_index != ttip_pkg::MAX_OFFSET) begin
        idx = char_index + 1'b1;
      end else begin
        idx = char_index;
      end
    end
    xpos  = (dstart_e == ttip_pkg::MAX_OFFSET) ? dstart_e : dstart_e + 1'b1;
    limit = ttip_pkg::kind_limit(kind_e);
  end

  always_comb begin
    case (phase_e)
      ttip_pkg::PH_LEAD, ttip_pkg::PH_START: begin
        mac_base = (base_e == ttip_pkg::BASE_AUTO) ? ttip_pkg::BASE_DEC : base_e;
        mac_acc  = acc_e;
      end
      ttip_pkg::PH_ZERO: begin
        mac_base = (base_e == ttip_pkg::BASE_AUTO) ? ttip_pkg::BASE_OCT : base_e;
        mac_acc  = '0;
      end
      ttip_pkg::PH_XSEEN: begin
        mac_base = ttip_pkg::BASE_HEX;
        mac_acc  = '0;
      end
      default: begin
        mac_base = active_e;
        mac_acc  = acc_e;
      end
    endcase
  end

  assign digit_ends = (d >= mac_base) || (mac_base < ttip_pkg::BASE_MIN);

  ttip_mac u_mac (
    .acc     (mac_acc),
    .base    (mac_base),
    .digit   (d),
    .limit   (limit),
    .ovf_in  (ovf_e),
    .acc_out (mac_acc_out),
    .ovf_out (mac_ovf_out)
  );

  always_comb begin
    phase_next       = phase_e;
    sign_neg_next    = sign_e;
    ovf_next         = ovf_e;
    dseen_next       = dseen_e;
    active_base_next = active_e;
    base_l_next      = base_e;
    kind_l_next      = kind_e;
    acc_next         = acc_e;
    char_index_next  = idx;
    dstart_next      = dstart_e;
    digit_go         = 1'b0;
    digit_dseen      = dseen_e;
    emit_valid       = 1'b0;
    emit_rec.bad_base   = 1'b0;
    emit_rec.dseen      = dseen_e;
    emit_rec.neg        = sign_e;
    emit_rec.ovf        = ovf_e;
    emit_rec.kind       = kind_e;
    emit_rec.mag        = acc_e;
    emit_rec.end_offset = idx;

    if (item.string_start && base_bad) begin
      emit_valid        = 1'b1;
      emit_rec.bad_base = 1'b1;
      emit_rec.dseen    = 1'b0;
    end else begin
      case (phase_e)
        ttip_pkg::PH_LEAD, ttip_pkg::PH_START: begin
          if (phase_e == ttip_pkg::PH_LEAD && ttip_pkg::is_blank(c)) begin
            phase_next = ttip_pkg::PH_LEAD;
          end else if (phase_e == ttip_pkg::PH_LEAD &&
                       (c == ttip_pkg::CH_PLUS || c == ttip_pkg::CH_MINUS)) begin
            sign_neg_next = (c == ttip_pkg::CH_MINUS);
            phase_next    = ttip_pkg::PH_START;
          end else begin
            dstart_next = idx;
            if ((base_e == ttip_pkg::BASE_AUTO || base_e == ttip_pkg::BASE_HEX) &&
                c == ttip_pkg::CH_ZERO) begin
              phase_next = ttip_pkg::PH_ZERO;
            end else begin
              digit_go = 1'b1;
            end
          end
        end
        ttip_pkg::PH_ZERO: begin
          if (c == ttip_pkg::CH_LX || c == ttip_pkg::CH_UX) begin
            phase_next = ttip_pkg::PH_XSEEN;
          end else begin
            digit_go    = 1'b1;
            digit_dseen = 1'b1;
          end
        end
        ttip_pkg::PH_XSEEN: begin
          if (d < ttip_pkg::DIGIT_W'(ttip_pkg::BASE_HEX)) begin
            dstart_next = idx;
            digit_go    = 1'b1;
          end else begin
            emit_valid          = 1'b1;
            emit_rec.dseen      = 1'b1;
            emit_rec.mag        = '0;
            emit_rec.end_offset = xpos;
            phase_next          = ttip_pkg::PH_IDLE;
          end
        end
        ttip_pkg::PH_DIGITS: begin
          digit_go = 1'b1;
        end
        default: begin
          phase_next = ttip_pkg::PH_IDLE;
        end
      endcase
    end

    if (digit_go) begin
      active_base_next = mac_base;
      if (digit_ends) begin
        emit_valid     = 1'b1;
        emit_rec.dseen = digit_dseen;
        emit_rec.mag   = mac_acc;
        phase_next     = ttip_pkg::PH_IDLE;
      end else begin
        acc_next   = mac_acc_out;
        ovf_next   = mac_ovf_out;
        dseen_next = 1'b1;
        phase_next = ttip_pkg::PH_DIGITS;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= ttip_pkg::PH_IDLE;
      sign_neg    <= 1'b0;
      ovf         <= 1'b0;
      dseen       <= 1'b0;
      active_base <= '0;
      base_l      <= '0;
      kind_l      <= '0;
      acc         <= '0;
      char_index  <= '0;
      dstart      <= '0;
    end else if (step) begin
      phase       <= phase_next;
      sign_neg    <= sign_neg_next;
      ovf         <= ovf_next;
      dseen       <= dseen_next;
      active_base <= active_base_next;
      base_l      <= base_l_next;
      kind_l      <= kind_l_next;
      acc         <= acc_next;
      char_index  <= char_index_next;
      dstart      <= dstart_next;
    end
  end

endmodule

@@ rtl/ttip_out_stage.sv @@
// Result register: clamps, signs and masks the value and holds the result transaction.
`timescale 1ns / 1ps

module ttip_out_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  ttip_pkg::emit_t rec,
  output logic            open_slot,
  ttip_out_if.source      out
);

  logic [ttip_pkg::VALUE_W-1:0]  mag_e;
  logic [ttip_pkg::VALUE_W-1:0]  neg_v;
  logic [ttip_pkg::VALUE_W-1:0]  lim;
  logic [ttip_pkg::VALUE_W-1:0]  mask;
  logic [ttip_pkg::VALUE_W-1:0]  val;
  logic                          neg;
  logic                          rng;
  logic [ttip_pkg::OFFSET_W-1:0] end_v;

  assign open_slot = !out.valid || out.ready;

  always_comb begin
    mag_e = rec.dseen ? rec.mag : '0;
    neg   = rec.dseen && rec.neg;
    neg_v = (~mag_e) + 1'b1;
    lim   = ttip_pkg::kind_limit(rec.kind);
    mask  = rec.kind[ttip_pkg::KIND_WIDE_BIT] ? ttip_pkg::MASK_64 : ttip_pkg::MASK_32;
    if (!rec.kind[ttip_pkg::KIND_SIGNED_BIT]) begin
      rng = rec.dseen && rec.ovf;
      val = rng ? mask : (neg ? neg_v : mag_e);
    end else begin
      rng = rec.dseen && (rec.ovf || (!neg && mag_e >= lim));
      if (rng) begin
        val = neg ? lim : lim - 1'b1;
      end else begin
        val = neg ? neg_v : mag_e;
      end
    end
    end_v = rec.dseen ? rec.end_offset : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else if (load) begin
      out.valid <= 1'b1;
    end else if (out.ready) begin
      out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out.parsed_value <= val & mask;
      out.range_error  <= rng;
      out.bad_base     <= rec.bad_base;
      out.end_offset   <= end_v;
    end
  end

endmodule
